### sv/pnsf_pkg.sv
// Shared types, constants, coefficient tables and rounding and saturation helpers for the pink noise filter.
package pnsf_pkg;

    // Sample and fixed-point formats
    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 24;
    localparam int IN_FRAC      = SAMPLE_WIDTH - 1;
    localparam int WQ_SHIFT     = FRAC_BITS - IN_FRAC;
    localparam int WQ_W         = FRAC_BITS + 1;
    localparam int GAIN_W       = 16;
    localparam int GAIN_ONE     = 15;
    localparam int OUT_SHIFT    = GAIN_ONE + FRAC_BITS - IN_FRAC;

    // Filter bank
    localparam int NUM_POLES    = 6;
    localparam int POLE_IDX_W   = $clog2(NUM_POLES);
    localparam int STATE_W      = 32;
    localparam int COEF_W       = 25;

    // Datapath widths
    localparam int SUM_W        = STATE_W + 3;
    localparam int SCALED_W     = STATE_W + 1;
    localparam int MUL_A_W      = SUM_W;
    localparam int MUL_B_W      = COEF_W;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int RND_W        = PROD_W - FRAC_BITS;

    // Input queue
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    // Reset gain: 0.5 in Q1.15
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);

    // Q.24 coefficients
    localparam logic signed [COEF_W-1:0] K_LEVEL  = COEF_W'(2233047);
    localparam logic signed [COEF_W-1:0] K_DIRECT = COEF_W'(8995943);
    localparam logic signed [COEF_W-1:0] K_DELAY  = COEF_W'(1944916);

    localparam logic signed [COEF_W-1:0] POLE_FB [NUM_POLES] = '{
        COEF_W'(16758090), COEF_W'(16665144), COEF_W'(16257122),
        COEF_W'(14537458), COEF_W'(9227469),  COEF_W'(-12777528)
    };
    localparam logic signed [COEF_W-1:0] POLE_IN [NUM_POLES] = '{
        COEF_W'(931436),  COEF_W'(1259565), COEF_W'(2581208),
        COEF_W'(5209084), COEF_W'(8941454), COEF_W'(-283501)
    };

    // Half an LSB at Q.24 and at the output scale
    localparam logic signed [PROD_W-1:0] Q24_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] OUT_HALF = PROD_W'(1) << (OUT_SHIFT - 1);

    // Word handed from the front queue to the back end
    typedef struct packed {
        logic                   valid;
        logic signed [WQ_W-1:0] wq;
    } pnsf_item_t;

    // Round half up from a product to Q.24
    function automatic logic signed [RND_W-1:0] round_q24(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] t;
        t = x + Q24_HALF;
        return t[PROD_W-1:FRAC_BITS];
    endfunction

    // Saturate a rounded value to the signed state range
    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [RND_W-1:0] r);
        logic [RND_W-STATE_W:0] hi;
        hi = r[RND_W-1:STATE_W-1];
        if ((&hi) || !(|hi))
            return r[STATE_W-1:0];
        else if (r[RND_W-1])
            return {1'b1, {(STATE_W-1){1'b0}}};
        else
            return {1'b0, {(STATE_W-1){1'b1}}};
    endfunction

    // Saturate a scaled value to the signed sample range
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [PROD_W-1:0] y
    );
        logic [PROD_W-SAMPLE_WIDTH:0] hi;
        hi = y[PROD_W-1:SAMPLE_WIDTH-1];
        if ((&hi) || !(|hi))
            return y[SAMPLE_WIDTH-1:0];
        else if (y[PROD_W-1])
            return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    endfunction

endpackage

### sv/pink_noise_shaping_filter.sv
// Top level of the pink noise shaping filter: gain register, input queue and filter back end.
// The back end takes a new word only as the last one finishes, as its single shared multiplier
// computes 16 products per word (two per pole, direct, delay, level and gain).
// Reset: filter states clear to zero, output gain returns to 0.5, queue and output empty.
module pink_noise_shaping_filter (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [pnsf_pkg::SAMPLE_WIDTH-1:0] white_sample,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [pnsf_pkg::SAMPLE_WIDTH-1:0] pink_sample,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [pnsf_pkg::GAIN_W-1:0]              cfg_data
);
    import pnsf_pkg::*;

    logic [GAIN_W-1:0] gain_reg;
    pnsf_item_t        item;
    logic              take;

    // Gain register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= GAIN_RESET;
        else if (cfg_valid && cfg_ready)
            gain_reg <= cfg_data;
    end

    // Input queue
    pnsf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .white_sample (white_sample),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .item         (item),
        .take         (take)
    );

    // Filter bank and output
    pnsf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .take        (take),
        .gain        (gain_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pink_sample (pink_sample)
    );

endmodule

### sv/pnsf_front.sv
// Front end: accepts white samples, widens them to Q.24 and queues them for the back end.
module pnsf_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [pnsf_pkg::SAMPLE_WIDTH-1:0] white_sample,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    output pnsf_pkg::pnsf_item_t                  item,
    input  logic                                  take
);
    import pnsf_pkg::*;

    logic signed [WQ_W-1:0] q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg;
    logic [QPTR_W-1:0]      rd_ptr_reg;
    logic [QCNT_W-1:0]      cnt_reg;
    logic [QCNT_W-1:0]      cnt_next;
    logic                   push;
    logic                   pop;
    logic signed [WQ_W-1:0] wq_in;

    // Exact widening of the sample to Q.24
    assign wq_in = $signed({white_sample, {WQ_SHIFT{1'b0}}});

    // Handshake
    assign in_stall = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign pop      = take && (cnt_reg != '0);

    // Head of queue
    assign item.valid = (cnt_reg != '0);
    assign item.wq    = q_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    // Queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= wq_in;
    end

endmodule

### sv/pnsf_back.sv
// Back end: one shared multiplier steps through the filter bank, the scaling and the output.
module pnsf_back (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  pnsf_pkg::pnsf_item_t                     item,
    output logic                                     take,
    input  logic [pnsf_pkg::GAIN_W-1:0]              gain,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [pnsf_pkg::SAMPLE_WIDTH-1:0] pink_sample
);
    import pnsf_pkg::*;

    // Step codes: poles occupy steps 0 .. 2*NUM_POLES-1, two products each
    localparam int STP_W = $clog2(2 * NUM_POLES + 7);
    localparam logic [STP_W-1:0] STP_DIR_ISSUE  = STP_W'(2 * NUM_POLES);
    localparam logic [STP_W-1:0] STP_DLY_ISSUE  = STP_W'(2 * NUM_POLES + 1);
    localparam logic [STP_W-1:0] STP_DLY_CAPT   = STP_W'(2 * NUM_POLES + 2);
    localparam logic [STP_W-1:0] STP_LVL_ISSUE  = STP_W'(2 * NUM_POLES + 3);
    localparam logic [STP_W-1:0] STP_LVL_CAPT   = STP_W'(2 * NUM_POLES + 4);
    localparam logic [STP_W-1:0] STP_GAIN_ISSUE = STP_W'(2 * NUM_POLES + 5);
    localparam logic [STP_W-1:0] STP_OUT        = STP_W'(2 * NUM_POLES + 6);
    localparam logic [STP_W-1:0] STP_FIRST_ACC  = STP_W'(2);
    localparam logic [STP_W-1:0] STP_FIRST_WB   = STP_W'(3);

    // Control
    logic                  busy_reg;
    logic [STP_W-1:0]      stp_reg;
    logic                  out_valid_reg;
    logic                  fin;
    logic                  adv;
    logic                  step;
    logic                  in_poles;
    logic                  stp_odd;
    logic [POLE_IDX_W-1:0] iss_idx;
    logic [STP_W-1:0]      wb_stp;
    logic [POLE_IDX_W-1:0] wb_idx;
    logic                  do_fbp;
    logic                  do_acc;
    logic                  do_wb;

    // Filter state
    logic signed [STATE_W-1:0] h_reg [NUM_POLES];
    logic signed [STATE_W-1:0] dly_reg;

    // Datapath
    logic signed [WQ_W-1:0]         wq_reg;
    logic signed [MUL_A_W-1:0]      mul_a;
    logic signed [MUL_B_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [PROD_W-1:0]       fbp_reg;
    logic signed [PROD_W-1:0]       acc_reg;
    logic signed [SUM_W-1:0]        sum_reg;
    logic signed [SUM_W-1:0]        dir_reg;
    logic signed [SCALED_W-1:0]     scaled_reg;
    logic signed [SAMPLE_WIDTH-1:0] pink_reg;
    logic signed [RND_W-1:0]        rnd_prod;
    logic signed [STATE_W-1:0]      pole_new;
    logic signed [PROD_W-1:0]       y_full;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;

    // Sequencing
    assign fin  = busy_reg && (stp_reg == STP_OUT);
    assign adv  = !(fin && out_valid_reg && out_stall);
    assign step = busy_reg && adv;
    assign take = item.valid && (!busy_reg || (fin && adv));

    assign in_poles = (stp_reg < STP_DIR_ISSUE);
    assign stp_odd  = stp_reg[0];
    assign iss_idx  = stp_reg[POLE_IDX_W:1];
    assign wb_stp   = stp_reg - STP_FIRST_WB;
    assign wb_idx   = wb_stp[POLE_IDX_W:1];

    assign do_fbp = in_poles && stp_odd;
    assign do_acc = !stp_odd && (stp_reg >= STP_FIRST_ACC) && (stp_reg <= STP_DIR_ISSUE);
    assign do_wb  = stp_odd && (stp_reg >= STP_FIRST_WB) && (stp_reg <= STP_DLY_ISSUE);

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (in_poles)
        begin
            if (stp_odd)
            begin
                mul_a = MUL_A_W'(wq_reg);
                mul_b = POLE_IN[iss_idx];
            end
            else
            begin
                mul_a = MUL_A_W'(h_reg[iss_idx]);
                mul_b = POLE_FB[iss_idx];
            end
        end
        else
        begin
            case (stp_reg)
                STP_DIR_ISSUE:
                begin
                    mul_a = MUL_A_W'(wq_reg);
                    mul_b = K_DIRECT;
                end
                STP_DLY_ISSUE:
                begin
                    mul_a = MUL_A_W'(wq_reg);
                    mul_b = K_DELAY;
                end
                STP_LVL_ISSUE:
                begin
                    mul_a = MUL_A_W'(sum_reg);
                    mul_b = K_LEVEL;
                end
                STP_GAIN_ISSUE:
                begin
                    mul_a = MUL_A_W'(scaled_reg);
                    mul_b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, gain});
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        prod_next = mul_a * mul_b;
    end

    // Rounding and saturation of registered products
    assign rnd_prod = round_q24(prod_reg);
    assign pole_new = sat_state(acc_reg[PROD_W-1:FRAC_BITS]);
    assign y_full   = (prod_reg + OUT_HALF) >>> OUT_SHIFT;
    assign y_sat    = sat_sample(y_full);

    // Control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            stp_reg       <= '0;
            out_valid_reg <= 1'b0;
            dly_reg       <= '0;
            for (int i = 0; i < NUM_POLES; i++)
                h_reg[i] <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (take)
            begin
                busy_reg <= 1'b1;
                stp_reg  <= '0;
            end
            else if (step && fin)
                busy_reg <= 1'b0;
            else if (step)
                stp_reg <= stp_reg + STP_W'(1);
            if (step)
            begin
                if (do_wb)
                    h_reg[wb_idx] <= pole_new;
                if (stp_reg == STP_DLY_CAPT)
                    dly_reg <= sat_state(rnd_prod);
                if (fin)
                    out_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            wq_reg  <= item.wq;
            sum_reg <= SUM_W'(dly_reg);
        end
        if (step)
        begin
            prod_reg <= prod_next;
            if (do_fbp)
                fbp_reg <= prod_reg;
            if (do_acc)
                acc_reg <= fbp_reg + prod_reg + Q24_HALF;
            if (do_wb)
                sum_reg <= sum_reg + SUM_W'(pole_new);
            if (stp_reg == STP_DLY_ISSUE)
                dir_reg <= rnd_prod[SUM_W-1:0];
            if (stp_reg == STP_DLY_CAPT)
                sum_reg <= sum_reg + dir_reg;
            if (stp_reg == STP_LVL_CAPT)
                scaled_reg <= rnd_prod[SCALED_W-1:0];
            if (fin)
                pink_reg <= y_sat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pink_sample = pink_reg;

    // Checks
    a_stp_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> stp_reg <= STP_OUT)
        else $error("step counter past the last step");

    a_take_start: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> busy_reg && (stp_reg == '0))
        else $error("taken word did not start at the first step");

    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        (step && fin) |=> out_valid_reg)
        else $error("finished word not presented at the output");

    a_dly_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && (stp_reg == STP_DLY_CAPT)) |=> $stable(dly_reg))
        else $error("delay term changed outside its update step");

endmodule

### bench/pink_noise_shaping_filter_test.sv
// Self-checking bench for the pink noise shaping filter: random traffic, fixed-point predictor.
module pink_noise_shaping_filter_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     SW         = pnsf_pkg::SAMPLE_WIDTH;
    localparam int     GW         = pnsf_pkg::GAIN_W;
    localparam int     FRAC       = 24;
    localparam int     WHITE_UP   = FRAC - (SW - 1);
    localparam int     GAIN_DOWN  = 15 + FRAC - (SW - 1);
    localparam int     POLES      = 6;
    localparam int     HOLD_LIMIT = 4000;
    localparam int     SETTLE     = 25;
    localparam longint S32_LO     = -(longint'(1) <<< 31);
    localparam longint S32_HI     = (longint'(1) <<< 31) - 1;
    localparam longint PINK_LO    = -(longint'(1) <<< (SW - 1));
    localparam longint PINK_HI    = (longint'(1) <<< (SW - 1)) - 1;

    // Q.24 filter coefficients
    localparam longint LEVEL_COEF  = 2233047;
    localparam longint DIRECT_COEF = 8995943;
    localparam longint DELAY_COEF  = 1944916;
    localparam longint FEEDBACK_COEF [POLES] = '{
        16758090, 16665144, 16257122, 14537458, 9227469, -12777528
    };
    localparam longint DRIVE_COEF [POLES] = '{
        931436, 1259565, 2581208, 5209084, 8941454, -283501
    };

    typedef logic signed [SW-1:0] sample_t;

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          in_valid     = 1'b0;
    logic          in_stall;
    sample_t       white_sample = '0;
    logic          out_valid;
    logic          out_stall    = 1'b0;
    sample_t       pink_sample;
    logic          cfg_valid    = 1'b0;
    logic          cfg_ready;
    logic [GW-1:0] cfg_data     = '0;

    // Predictor state
    logic [GW-1:0] gain_setting = GW'(16384);
    longint        pole_state [POLES];
    longint        delayed_term = 0;

    sample_t       white_pending [$];
    sample_t       pink_expected [$];
    int            words_queued  = 0;
    int            words_checked = 0;
    int            mismatches    = 0;

    int            send_pause, send_calm;
    int            stall_left, stall_calm;
    int            idle_cycles;

    pink_noise_shaping_filter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .white_sample (white_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pink_sample  (pink_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // floor((x + half LSB) / 2^n)
    function automatic longint round_half_up(input longint x, input int n);
        return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // One filter step: updates the pole states and the delayed term, returns the pink word
    function automatic sample_t shape_pink(input sample_t white);
        longint wq;
        longint acc;
        longint total;
        longint scaled;
        longint y;
        wq = longint'(white) <<< WHITE_UP;
        for (int i = 0; i < POLES; i++)
        begin
            acc = FEEDBACK_COEF[i] * pole_state[i] + DRIVE_COEF[i] * wq;
            pole_state[i] = clamp_to(round_half_up(acc, FRAC), S32_LO, S32_HI);
        end
        // delayed term enters before its own update
        total = delayed_term + round_half_up(wq * DIRECT_COEF, FRAC);
        for (int i = 0; i < POLES; i++)
            total += pole_state[i];
        scaled = round_half_up(total * LEVEL_COEF, FRAC);
        y = round_half_up(scaled * longint'({48'd0, gain_setting}), GAIN_DOWN);
        y = clamp_to(y, PINK_LO, PINK_HI);
        delayed_term = clamp_to(round_half_up(wq * DELAY_COEF, FRAC), S32_LO, S32_HI);
        return y[SW-1:0];
    endfunction

    // Idle length: mostly short, a few long, with occasional runs of no idling
    function automatic int draw_pause(inout int calm_left);
        int roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 3)
        begin
            calm_left = $urandom_range(16, 64);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 16);
        return $urandom_range(30, 100);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    task automatic push_white(input sample_t v);
        white_pending.push_back(v);
        words_queued++;
    endtask

    task automatic write_gain(input logic [GW-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        gain_setting = value;
    endtask

    task automatic wait_drained();
        while (words_checked != words_queued)
            @(posedge clk);
    endtask

    // Random words: uniform noise, corner values, and runs of a constant that push
    // the slow poles toward their limits
    task automatic queue_random(input int count);
        sample_t corner_words [5];
        sample_t v;
        int      left;
        int      run_len;
        corner_words = '{sample_t'(PINK_HI), sample_t'(PINK_LO), '0, '1, sample_t'(1)};
        left = count;
        while (left > 0)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    v = ($urandom_range(1) == 1) ? corner_words[$urandom_range(1)]
                                                 : sample_t'($urandom);
                    run_len = $urandom_range(4, 48);
                    if (run_len > left)
                        run_len = left;
                    repeat (run_len)
                        push_white(v);
                    left -= run_len;
                end
                2:
                begin
                    push_white(corner_words[$urandom_range(4)]);
                    left--;
                end
                default:
                begin
                    push_white(sample_t'($urandom));
                    left--;
                end
            endcase
        end
    endtask

    // Driver: hands out queued white words, predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            white_sample <= '0;
            send_pause   <= 0;
            send_calm    = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                pink_expected.push_back(shape_pink(white_sample));
            if (send_pause > 0)
            begin
                in_valid   <= 1'b0;
                send_pause <= send_pause - 1;
            end
            else if (white_pending.size() > 0)
            begin
                in_valid     <= 1'b1;
                white_sample <= white_pending.pop_front();
                send_pause   <= draw_pause(send_calm);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: random stall, compare each accepted pink word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            stall_calm = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pink_expected.size() == 0)
                    report_mismatch($sformatf("unexpected pink word %0d", pink_sample));
                else
                begin
                    sample_t want;
                    want = pink_expected.pop_front();
                    if (pink_sample !== want)
                        report_mismatch($sformatf("pink_sample word %0d: got %0d, want %0d",
                                                  words_checked, pink_sample, want));
                    words_checked++;
                end
            end
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= draw_pause(stall_calm);
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= HOLD_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Sequence: directed corners, then random phases under several gains
    initial
    begin
        logic [GW-1:0] gain_plan [6];
        for (int i = 0; i < POLES; i++)
            pole_state[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset gain: corners, then full-scale runs of each sign
        push_white('0);
        push_white(sample_t'(PINK_HI));
        push_white(sample_t'(PINK_LO));
        push_white('1);
        push_white(sample_t'(1));
        repeat (4) push_white(sample_t'(PINK_HI));
        repeat (4) push_white(sample_t'(PINK_LO));
        wait_drained();

        // gain near two drives the output into both clamps
        write_gain('1);
        repeat (6) push_white(sample_t'(PINK_HI));
        repeat (6) push_white(sample_t'(PINK_LO));
        wait_drained();

        gain_plan = '{GW'(0), GW'(32768), GW'(1), '1,
                      GW'($urandom_range(0, 65535)), GW'($urandom_range(32769, 65535))};
        foreach (gain_plan[p])
        begin
            write_gain(gain_plan[p]);
            queue_random(130);
            wait_drained();
        end

        repeat (SETTLE) @(posedge clk);
        if (pink_expected.size() != 0)
            report_mismatch($sformatf("%0d pink words never arrived", pink_expected.size()));
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
